[rtl/motor_feedback_multiturn_tracker_assert.svh]
// Assertion macros for the multi-turn tracker.
`ifndef MOTOR_FEEDBACK_MULTITURN_TRACKER_ASSERT_SVH
`define MOTOR_FEEDBACK_MULTITURN_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define MFT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tracker assertion failed");
// Next-cycle implication.
`define MFT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tracker assertion failed");
`else
`define MFT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MFT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/mft_pkg.sv]
// Types and constants shared by the multi-turn tracker modules.
package mft_pkg;

	localparam int MOTORS_PER_BUS = 8;
	localparam int BUS_COUNT      = 2;
	localparam int SLOTS          = MOTORS_PER_BUS * BUS_COUNT;
	localparam int SLOT_W         = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [16:0] HALF_TURN  = 17'd4096;
	localparam int          TURN_SHIFT = 13;  // 8192 counts per turn
	localparam logic [7:0]  FC_MAX     = 8'hFF;

	localparam logic [10:0] BASE_ID_RESET      = 11'd513;
	localparam logic [7:0]  CALIB_FRAMES_RESET = 8'd50;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ID      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CALIB_FRAMES = 1'd1;

	localparam int QDEPTH = 2;

	typedef struct packed {
		logic        bus;
		logic [10:0] std_id;
		logic [15:0] angle_word;
		logic [15:0] speed_word;
		logic [15:0] current_word;
		logic [7:0]  temperature;
	} in_t;

	typedef struct packed {
		logic               out_bus;
		logic [2:0]         motor_index;
		logic [15:0]        angle;
		logic [15:0]        speed;
		logic [15:0]        current;
		logic [7:0]         temp_out;
		logic signed [31:0] turn_count;
		logic signed [31:0] unwrapped_angle;
		logic               calibrating;
	} out_t;

	typedef struct packed {
		logic [10:0] base_id;
		logic [7:0]  calib_frames;
	} cfg_t;

	typedef struct packed {
		logic              bus;
		logic [SLOT_W-1:0] slot;
		logic [2:0]        motor_index;
		logic [15:0]       angle_word;
		logic [15:0]       speed_word;
		logic [15:0]       current_word;
		logic [7:0]        temperature;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

[rtl/motor_feedback_multiturn_tracker.sv]
// Top level of the motor feedback multi-turn tracker.
// Takes decoded feedback frames at up to one transfer per clock while
// frame_stall is low and returns, for each frame whose identifier falls in
// base_id..base_id+7 on a known bus, one result with the passed-through
// payload, the signed turn count and the multi-turn angle (turns*8192 +
// angle - offset, mod 2^32). Frames outside the window are taken and
// dropped without a result. The result passes through the two-entry queue,
// written by the filter at the input transfer, and the result register,
// loaded by the back end when it pops the entry; there the per-motor state
// (sixteen entries held in flip-flops, cleared by reset) is read and written
// in the same cycle, so frames for the same motor may follow each other back
// to back. The sustained rate is one frame per cycle while result_stall is
// low, limited by that single read-modify-write of the motor table. The
// first calib_frames+1 frames of a motor capture its zero offset and flag
// calibrating; the frame counter saturates at 255. Configuration is written
// by the user via cfg_wen/cfg_index/cfg_wdata while no frame is in flight (not enforced).
`include "motor_feedback_multiturn_tracker_assert.svh"

module motor_feedback_multiturn_tracker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               frame_valid,
	output logic                               frame_stall,
	input  mft_pkg::in_t                       frame,
	output logic                               result_valid,
	input  logic                               result_stall,
	output mft_pkg::out_t                      result,
	input  logic                               cfg_wen,
	input  logic [mft_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mft_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import mft_pkg::*;

	cfg_t     cfg_q;
	q_stat_t  q_stat;
	q_entry_t push_entry;
	q_entry_t pop_entry;
	logic     push;
	logic     pop;

	// Configuration registers: plain writes, no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_id      <= BASE_ID_RESET;
			cfg_q.calib_frames <= CALIB_FRAMES_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_BASE_ID:      cfg_q.base_id      <= cfg_wdata[10:0];
				REG_CALIB_FRAMES: cfg_q.calib_frames <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Front end: identifier filter and slot selection.
	mft_front u_front (
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame       (frame),
		.cfg         (cfg_q),
		.q_stat      (q_stat),
		.push        (push),
		.entry       (push_entry)
	);

	// Decouples the input transfer from a stalled result.
	mft_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (push_entry),
		.pop      (pop),
		.rd_entry (pop_entry),
		.stat     (q_stat)
	);

	// Back end: turn tracking and result register.
	mft_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.entry        (pop_entry),
		.q_stat       (q_stat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// A frame pushed into the queue leaves it non-empty.
	`MFT_ASSERT_NXT(a_push_not_empty, clk, arst_n, push, !q_stat.empty)
	// Every pop loads the result register.
	`MFT_ASSERT_NXT(a_pop_loads_result, clk, arst_n, pop, result_valid)
	// A calibrating frame sits on a whole-turn boundary.
	`MFT_ASSERT_IMP(a_cal_whole_turn, clk, arst_n, result_valid && result.calibrating,
		result.unwrapped_angle[TURN_SHIFT-1:0] == '0)

endmodule

[rtl/mft_front.sv]
// Front end: takes frames, filters by identifier window and builds queue entries.
module mft_front (
	input  logic             frame_valid,
	output logic             frame_stall,
	input  mft_pkg::in_t     frame,
	input  mft_pkg::cfg_t    cfg,
	input  mft_pkg::q_stat_t q_stat,
	output logic             push,
	output mft_pkg::q_entry_t entry
);
	import mft_pkg::*;

	logic [10:0] diff;
	logic        hit;

	assign diff = frame.std_id - cfg.base_id;
	assign hit  = (32'(frame.bus) < BUS_COUNT) && (frame.std_id >= cfg.base_id)
		&& (32'(diff) < MOTORS_PER_BUS);

	assign frame_stall = q_stat.full;
	assign push        = frame_valid && !q_stat.full && hit;

	always_comb begin
		entry.bus          = frame.bus;
		entry.slot         = SLOT_W'(32'(frame.bus) * MOTORS_PER_BUS + 32'(diff));
		entry.motor_index  = diff[2:0];
		entry.angle_word   = frame.angle_word;
		entry.speed_word   = frame.speed_word;
		entry.current_word = frame.current_word;
		entry.temperature  = frame.temperature;
	end

endmodule

[rtl/mft_queue.sv]
// Two-entry queue between front end and back end.
module mft_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mft_pkg::q_entry_t wr_entry,
	input  logic              pop,
	output mft_pkg::q_entry_t rd_entry,
	output mft_pkg::q_stat_t  stat
);
	import mft_pkg::*;

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	q_entry_t             entry_q [QDEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (32'(p) == QDEPTH - 1) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= wr_entry;
	end

	assign rd_entry   = entry_q[rd_ptr_q];
	assign stat.full  = (32'(count_q) == QDEPTH);
	assign stat.empty = (count_q == '0);

endmodule

[rtl/mft_back.sv]
// Back end: per-motor turn tracking, offset capture and result register.
module mft_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mft_pkg::cfg_t     cfg,
	input  mft_pkg::q_entry_t entry,
	input  mft_pkg::q_stat_t  q_stat,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_stall,
	output mft_pkg::out_t     result
);
	import mft_pkg::*;

	logic [15:0] last_q  [SLOTS];
	logic [15:0] off_q   [SLOTS];
	logic [31:0] turn_q  [SLOTS];
	logic [7:0]  fc_q    [SLOTS];

	logic        valid_q;
	out_t        res_q;

	logic [15:0] last_rd, off_rd, off_new;
	logic [31:0] turn_rd, turn_new, total;
	logic [7:0]  fc_rd, fc_new;
	logic        cal, up_jump, down_jump;

	assign pop = !q_stat.empty && (!valid_q || !result_stall);

	always_comb begin
		last_rd   = last_q[entry.slot];
		off_rd    = off_q[entry.slot];
		turn_rd   = turn_q[entry.slot];
		fc_rd     = fc_q[entry.slot];
		cal       = fc_rd <= cfg.calib_frames;
		fc_new    = (fc_rd == FC_MAX) ? fc_rd : fc_rd + 8'd1;
		up_jump   = {1'b0, entry.angle_word} > ({1'b0, last_rd} + HALF_TURN);
		down_jump = ({1'b0, entry.angle_word} + HALF_TURN) < {1'b0, last_rd};
		if (cal)
			turn_new = turn_rd;
		else if (up_jump)
			turn_new = turn_rd - 32'd1;
		else if (down_jump)
			turn_new = turn_rd + 32'd1;
		else
			turn_new = turn_rd;
		off_new = cal ? entry.angle_word : off_rd;
		total   = {turn_new[31-TURN_SHIFT:0], TURN_SHIFT'(0)}
			+ 32'(entry.angle_word) - 32'(off_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				last_q[i] <= '0;
				off_q[i]  <= '0;
				turn_q[i] <= '0;
				fc_q[i]   <= '0;
			end
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				last_q[entry.slot] <= entry.angle_word;
				off_q[entry.slot]  <= off_new;
				turn_q[entry.slot] <= turn_new;
				fc_q[entry.slot]   <= fc_new;
				valid_q            <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.out_bus         <= entry.bus;
			res_q.motor_index     <= entry.motor_index;
			res_q.angle           <= entry.angle_word;
			res_q.speed           <= entry.speed_word;
			res_q.current         <= entry.current_word;
			res_q.temp_out        <= entry.temperature;
			res_q.turn_count      <= turn_new;
			res_q.unwrapped_angle <= total;
			res_q.calibrating     <= cal;
		end
	end

	assign result_valid = valid_q;
	assign result       = res_q;

endmodule
